// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the receiver's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define YMR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define YMR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset.
`define YMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ymr_pkg.sv -----
// Types and constants of the YMODEM frame receiver.
package ymr_pkg;

  // Protocol bytes, CRC-16/XMODEM polynomial and gap timer constants
  localparam logic [7:0]  BYTE_SOH  = 8'h01;
  localparam logic [7:0]  BYTE_EOT  = 8'h04;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] GAP_RESET = 16'd200;
  localparam logic [15:0] GAP_MAX   = 16'hFFFF;

  // Input event codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_DROP    = 3'd1,
    KIND_HEADER  = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_CRCBYTE = 3'd4,
    KIND_GOOD    = 3'd5,
    KIND_CRCERR  = 3'd6,
    KIND_EOT     = 3'd7
  } kind_e;

  // Input beat
  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } in_t;

  // Result beat
  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [6:0] payload_index;
    logic [7:0] frame_number;
    logic       gap_discard;
  } out_t;

endpackage

// ----- rtl/ymr_crc_byte.sv -----
// Bytewise CRC-16/XMODEM update, unrolled into XOR logic.
module ymr_crc_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  // Shift eight bits through the polynomial
  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ ymr_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

// ----- rtl/ymr_framer.sv -----
// Framing state, gap timer and result decode of the receiver.
`include "assert_macros.svh"

module ymr_framer #(
  parameter int unsigned PAYLOAD_BYTES = 128
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  ymr_pkg::in_t   item_i,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_data_i,
  output ymr_pkg::out_t  result_o
);

  localparam int unsigned POS_W = $clog2(PAYLOAD_BYTES + 5);

  localparam logic [POS_W-1:0] POS_START  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_ID     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CPL    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_DATA   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(PAYLOAD_BYTES + 3);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(PAYLOAD_BYTES + 4);

  logic [POS_W-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]       id_q, id_d;
  logic [15:0]      crc_q, crc_d, crc_next;
  logic [7:0]       crc_hi_q, crc_hi_d;
  logic [15:0]      gap_q, gap_d;
  logic [15:0]      gap_limit_q;
  logic [POS_W+6:0] pidx_wide;
  ymr_pkg::kind_e   kind;
  logic             gap_drop;

  ymr_crc_byte u_crc (
    .crc_i  (crc_q),
    .byte_i (item_i.in_byte),
    .crc_o  (crc_next)
  );

  // Offset into the data field, widened with zeros; the result keeps only its low 7 bits
  assign pidx_wide = {7'd0, pos_eff - POS_DATA};

  // Decode one beat and work out the next state
  always_comb begin
    pos_d    = pos_q;
    id_d     = id_q;
    crc_d    = crc_q;
    crc_hi_d = crc_hi_q;
    gap_d    = gap_q;
    pos_eff  = pos_q;
    gap_drop = 1'b0;
    kind     = ymr_pkg::KIND_TICK;
    if (item_i.op == ymr_pkg::OP_TICK) begin
      if (gap_q != ymr_pkg::GAP_MAX) begin
        gap_d = gap_q + 16'd1;
      end
    end else begin
      gap_d = '0;
      // Drop a partial frame after too long a silence
      if (gap_q > gap_limit_q && pos_q != POS_START) begin
        pos_eff  = POS_START;
        pos_d    = POS_START;
        gap_drop = 1'b1;
      end
      priority if (pos_eff == POS_START) begin
        if (item_i.in_byte == ymr_pkg::BYTE_SOH) begin
          pos_d = POS_ID;
          crc_d = '0;
          kind  = ymr_pkg::KIND_HEADER;
        end else if (item_i.in_byte == ymr_pkg::BYTE_EOT) begin
          id_d = '0;
          kind = ymr_pkg::KIND_EOT;
        end else begin
          kind = ymr_pkg::KIND_DROP;
        end
      end else if (pos_eff == POS_ID) begin
        if (item_i.in_byte == id_q) begin
          pos_d = POS_CPL;
          kind  = ymr_pkg::KIND_HEADER;
        end else begin
          pos_d = POS_START;
          kind  = ymr_pkg::KIND_DROP;
        end
      end else if (pos_eff == POS_CPL) begin
        if (item_i.in_byte == ~id_q) begin
          pos_d = POS_DATA;
          kind  = ymr_pkg::KIND_HEADER;
        end else begin
          pos_d = POS_START;
          kind  = ymr_pkg::KIND_DROP;
        end
      end else if (pos_eff < POS_CRC_HI) begin
        crc_d = crc_next;
        pos_d = pos_eff + POS_W'(1);
        kind  = ymr_pkg::KIND_PAYLOAD;
      end else if (pos_eff == POS_CRC_HI) begin
        crc_hi_d = item_i.in_byte;
        pos_d    = pos_eff + POS_W'(1);
        kind     = ymr_pkg::KIND_CRCBYTE;
      end else begin
        if ({crc_hi_q, item_i.in_byte} == crc_q) begin
          id_d = id_q + 8'd1;
          kind = ymr_pkg::KIND_GOOD;
        end else begin
          kind = ymr_pkg::KIND_CRCERR;
        end
        pos_d = POS_START;
      end
    end
  end

  // Assemble the result beat
  always_comb begin
    result_o.kind          = kind;
    result_o.out_byte      = (item_i.op == ymr_pkg::OP_TICK) ? 8'd0 : item_i.in_byte;
    result_o.payload_index = (kind == ymr_pkg::KIND_PAYLOAD) ? pidx_wide[6:0] : 7'd0;
    result_o.frame_number  = id_q;
    result_o.gap_discard   = gap_drop;
  end

  // Advance framing state once per consumed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_START;
      id_q     <= '0;
      crc_q    <= '0;
      crc_hi_q <= '0;
      gap_q    <= '0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      id_q     <= id_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
      gap_q    <= gap_d;
    end
  end

  // Hold the gap limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= ymr_pkg::GAP_RESET;
    end else if (cfg_we_i) begin
      gap_limit_q <= cfg_data_i;
    end
  end

  `YMR_ASSERT(a_pos_range, pos_q <= POS_LAST, "frame position out of range")
  `YMR_ASSERT_NEXT(a_eot_clears_id, step_i && kind == ymr_pkg::KIND_EOT, id_q == 8'd0, "EOT did not clear id")
  `YMR_ASSERT_NEXT(a_good_adv_id, step_i && kind == ymr_pkg::KIND_GOOD, id_q == $past(id_q) + 8'd1, "good frame did not advance id")
  `YMR_ASSERT_NEXT(a_end_restarts, step_i && (kind == ymr_pkg::KIND_GOOD || kind == ymr_pkg::KIND_CRCERR), pos_q == POS_START, "frame end did not restart framing")

endmodule

// ----- rtl/ymodem_frame_receiver.sv -----
// Top level of the YMODEM 128-byte frame receiver with CRC-16/XMODEM check.
//
//   channel  direction  handshake                payload
//   -------  ---------  -----------------------  ----------------------------
//   in       sink       in_valid_i / in_ready_o   in_data_i  (op, in_byte)
//   out      source     out_valid_o / out_ready_i out_data_o (kind .. gap_discard)
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_data_i (gap_limit)
//
// One beat per cycle sustained while out_ready_i stays high; a beat passes the input then the output register.
// The single path is input register -> framer decode and CRC byte update -> output register.
// Reset clears all framing state and loads gap_limit with 200; no clearing pass.
// An output stall holds the result; one more beat waits in the input register,
// then in_ready_o drops until the result is taken.
`include "assert_macros.svh"

module ymodem_frame_receiver #(
  parameter int unsigned PAYLOAD_BYTES = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ymr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ymr_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i
);

  logic          in_valid_q;
  ymr_pkg::in_t  in_data_q;
  logic          out_valid_q;
  ymr_pkg::out_t out_data_q;
  ymr_pkg::out_t result;
  logic          out_free;
  logic          step;

  // Move a beat into the output register whenever it is empty or draining
  assign out_free    = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && out_free;
  assign in_ready_o  = !in_valid_q || out_free;
  assign cfg_ready_o = 1'b1;

  ymr_framer #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_data_q),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `YMR_ASSERT_IMPL(a_stall_cause, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i, "input stalled without output backpressure")
  `YMR_ASSERT_NEXT(a_step_fills_out, step, out_valid_o, "consumed beat produced no result")
  `YMR_ASSERT_IMPL(a_tick_clean, out_valid_o && out_data_o.kind == ymr_pkg::KIND_TICK, out_data_o.gap_discard == 1'b0 && out_data_o.out_byte == 8'd0, "tick result carries byte data")

endmodule
